>>> hw/rtl/blake2b_hash_engine_unit_assert.svh
// assertion macros of the hash engine, included by bhe_ctrl
// expects clk_i and rst_ni in the including scope
`ifndef BLAKE2B_HASH_ENGINE_UNIT_ASSERT_SVH
`define BLAKE2B_HASH_ENGINE_UNIT_ASSERT_SVH

// property must hold on every clock once out of reset
`define BHE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen once out of reset
`define BHE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/bhe_pkg.sv
// types, constants and tables of the blake2b hash engine
// no dependencies
`timescale 1ns / 1ps

package bhe_pkg;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0000;
  localparam logic [7:0]  BLOCK_BYTES = 8'd128;
  localparam logic [6:0]  MAX_LEN = 7'd64;
  localparam logic [6:0]  DEF_DIGEST_LEN = 7'd64;
  localparam logic [6:0]  DEF_KEY_LEN = 7'd0;
  localparam logic [3:0]  LAST_ROUND = 4'd11;

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // state word indices of the eight mixing steps of a round
  localparam logic [3:0] GA [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd2, 4'd3};
  localparam logic [3:0] GB [8] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd5, 4'd6, 4'd7, 4'd4};
  localparam logic [3:0] GC [8] = '{4'd8, 4'd9, 4'd10, 4'd11, 4'd10, 4'd11, 4'd8, 4'd9};
  localparam logic [3:0] GD [8] = '{4'd12, 4'd13, 4'd14, 4'd15, 4'd15, 4'd12, 4'd13, 4'd14};

  typedef enum logic [0:0] {
    CFG_DIGEST_LEN = 1'b0,
    CFG_KEY_LEN    = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_BYTE, S_PAD, S_INIT, S_ROUND, S_FEED, S_OUT, S_START
  } state_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       finish;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic blk_count;
    logic write_byte;
    logic pad;
    logic init_v;
    logic round_step;
    logic feed;
    logic out_next;
    logic start;
  } dp_cmd_t;

  typedef struct packed {
    logic need_compress;
    logic finish;
    logic final_blk;
    logic round_done;
    logic last_word;
  } dp_sts_t;

  function automatic logic [6:0] eff_digest(input logic [6:0] raw);
    logic [6:0] r;
    r = raw;
    if (raw == 7'd0) r = 7'd1;
    else if (raw > MAX_LEN) r = MAX_LEN;
    return r;
  endfunction

  function automatic logic [6:0] eff_key(input logic [6:0] raw);
    return (raw > MAX_LEN) ? MAX_LEN : raw;
  endfunction

  function automatic logic [63:0] param_word(input logic [6:0] dl, input logic [6:0] kl);
    return PARAM_BASE ^ {49'd0, kl, 8'd0} ^ {57'd0, dl};
  endfunction

endpackage

>>> hw/rtl/blake2b_hash_engine_unit.sv
// top level of the blake2b keyed hash engine
// channel    | valid       | stall       | payload
// input      | in_valid_i  | in_stall_o  | in_data_i (byte, byte flag, finish)
// output     | out_valid_o | out_stall_i | out_data_o (digest word, bytes, last)
// config     | cfg_we_i    | -           | cfg_idx_i, cfg_data_i
// a byte passes the idle, dispatch and byte states; a full block adds init, the 192 half
// mixing steps of the shared round unit and feed; a finish adds a pad state, one more
// block, the digest beats and a restart state
// reset clears to a fresh unkeyed message with a 64-byte digest, no clearing pass
// input is stalled from acceptance until the item is done; digest beats hold under stall
// depends on bhe_pkg, bhe_ctrl, bhe_datapath
`timescale 1ns / 1ps

module blake2b_hash_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bhe_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bhe_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [6:0]         cfg_data_i
);

  bhe_pkg::dp_cmd_t cmd;
  bhe_pkg::dp_sts_t sts;

  bhe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bhe_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

>>> hw/rtl/bhe_datapath.sv
// datapath: chain value, counter, block buffer, round state and digest output
// depends on bhe_pkg
`timescale 1ns / 1ps

module bhe_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bhe_pkg::in_item_t  in_data_i,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [6:0]         cfg_data_i,
  input  bhe_pkg::dp_cmd_t   cmd_i,
  output bhe_pkg::dp_sts_t   sts_o,
  output bhe_pkg::out_item_t out_data_o
);

  bhe_pkg::in_item_t item_q;
  logic [6:0]        dlen_q, dlen_d, klen_q, klen_d;
  logic [63:0]       h_q [8];
  logic [127:0]      t_q;
  logic [7:0][7:0]   buf_q [16];
  logic [7:0]        fill_q;
  logic [6:0]        seen_q;
  logic [63:0]       v_q [16];
  logic [3:0]        rnd_q, sub_q;
  logic              final_q;
  logic [2:0]        wrd_q;

  logic [6:0]  dl, kl, dl_new, kl_new, seen_inc, rem, dl_m1;
  logic        in_key, start_now;
  logic [7:0]  fill_pad;
  logic [3:0]  row, ga, gb, gc, gd, sidx;
  logic [2:0]  g;
  logic        half;
  logic [63:0] x, va, vb, vc, vd, a1, d1x, d1, c1, b1x, b1, wmask;
  logic [3:0]  vbytes;

  always_comb begin
    dlen_d = dlen_q;
    klen_d = klen_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bhe_pkg::CFG_DIGEST_LEN: dlen_d = cfg_data_i;
        bhe_pkg::CFG_KEY_LEN:    klen_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dl        = bhe_pkg::eff_digest(dlen_q);
  assign kl        = bhe_pkg::eff_key(klen_q);
  assign dl_new    = bhe_pkg::eff_digest(dlen_d);
  assign kl_new    = bhe_pkg::eff_key(klen_d);
  assign in_key    = (kl != 7'd0) && (seen_q < kl);
  assign seen_inc  = seen_q + 7'd1;
  assign fill_pad  = in_key ? bhe_pkg::BLOCK_BYTES : fill_q;
  assign start_now = cfg_we_i || cmd_i.start;

  // half of one mixing step per cycle
  assign g    = sub_q[3:1];
  assign half = sub_q[0];
  assign row  = (rnd_q >= 4'd10) ? (rnd_q - 4'd10) : rnd_q;
  assign ga   = bhe_pkg::GA[g];
  assign gb   = bhe_pkg::GB[g];
  assign gc   = bhe_pkg::GC[g];
  assign gd   = bhe_pkg::GD[g];
  assign sidx = bhe_pkg::SIGMA[row][sub_q];
  assign x    = buf_q[sidx];
  assign va   = v_q[ga];
  assign vb   = v_q[gb];
  assign vc   = v_q[gc];
  assign vd   = v_q[gd];
  assign a1   = va + vb + x;
  assign d1x  = vd ^ a1;
  assign d1   = half ? {d1x[15:0], d1x[63:16]} : {d1x[31:0], d1x[63:32]};
  assign c1   = vc + d1;
  assign b1x  = vb ^ c1;
  assign b1   = half ? {b1x[62:0], b1x[63]} : {b1x[23:0], b1x[63:24]};

  // digest word truncation
  assign rem    = dl - {1'b0, wrd_q, 3'b000};
  assign vbytes = (rem >= 7'd8) ? 4'd8 : rem[3:0];
  assign dl_m1  = dl - 7'd1;
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      wmask[j*8 +: 8] = (4'(j) < vbytes) ? 8'hff : 8'h00;
    end
  end

  assign out_data_o.digest_word = h_q[wrd_q] & wmask;
  assign out_data_o.valid_bytes = vbytes;
  assign out_data_o.last_word   = (wrd_q == dl_m1[5:3]);

  assign sts_o.need_compress = item_q.byte_valid && !in_key &&
                               (fill_q == bhe_pkg::BLOCK_BYTES);
  assign sts_o.finish        = item_q.finish;
  assign sts_o.final_blk     = final_q;
  assign sts_o.round_done    = (rnd_q == bhe_pkg::LAST_ROUND) && (sub_q == 4'd15);
  assign sts_o.last_word     = out_data_o.last_word;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
    end
    if (cmd_i.init_v) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
      for (int i = 0; i < 4; i++) begin
        v_q[i+8] <= bhe_pkg::IV[i];
      end
      v_q[12] <= bhe_pkg::IV[4] ^ t_q[63:0];
      v_q[13] <= bhe_pkg::IV[5] ^ t_q[127:64];
      v_q[14] <= bhe_pkg::IV[6] ^ {64{final_q}};
      v_q[15] <= bhe_pkg::IV[7];
    end else if (cmd_i.round_step) begin
      v_q[ga] <= a1;
      v_q[gb] <= b1;
      v_q[gc] <= c1;
      v_q[gd] <= d1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlen_q  <= bhe_pkg::DEF_DIGEST_LEN;
      klen_q  <= bhe_pkg::DEF_KEY_LEN;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= (i == 0) ?
                  (bhe_pkg::IV[0] ^
                   bhe_pkg::param_word(bhe_pkg::DEF_DIGEST_LEN, bhe_pkg::DEF_KEY_LEN)) :
                  bhe_pkg::IV[i];
      end
      t_q     <= '0;
      for (int i = 0; i < 16; i++) buf_q[i] <= '0;
      fill_q  <= '0;
      seen_q  <= '0;
      rnd_q   <= '0;
      sub_q   <= '0;
      final_q <= 1'b0;
      wrd_q   <= '0;
    end else begin
      dlen_q <= dlen_d;
      klen_q <= klen_d;
      if (start_now) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= (i == 0) ? (bhe_pkg::IV[0] ^ bhe_pkg::param_word(dl_new, kl_new)) :
                               bhe_pkg::IV[i];
        end
        t_q     <= '0;
        for (int i = 0; i < 16; i++) buf_q[i] <= '0;
        fill_q  <= '0;
        seen_q  <= '0;
        final_q <= 1'b0;
        wrd_q   <= '0;
      end else begin
        if (cmd_i.blk_count) begin
          t_q     <= t_q + 128'(bhe_pkg::BLOCK_BYTES);
          fill_q  <= '0;
          final_q <= 1'b0;
        end
        if (cmd_i.write_byte && item_q.byte_valid) begin
          if (in_key) begin
            buf_q[seen_q[6:3]][seen_q[2:0]] <= item_q.byte_value;
            seen_q <= seen_inc;
            fill_q <= (seen_inc == kl) ? bhe_pkg::BLOCK_BYTES : {1'b0, seen_inc};
          end else begin
            buf_q[fill_q[6:3]][fill_q[2:0]] <= item_q.byte_value;
            fill_q <= fill_q + 8'd1;
          end
        end
        if (cmd_i.pad) begin
          fill_q  <= fill_pad;
          t_q     <= t_q + 128'(fill_pad);
          final_q <= 1'b1;
          for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 8; j++) begin
              if (8'(i*8+j) >= fill_pad) buf_q[i][j] <= 8'h00;
            end
          end
        end
        if (cmd_i.init_v) begin
          rnd_q <= '0;
          sub_q <= '0;
        end else if (cmd_i.round_step) begin
          sub_q <= sub_q + 4'd1;
          if (sub_q == 4'd15) rnd_q <= rnd_q + 4'd1;
        end
        if (cmd_i.feed) begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
          wrd_q <= '0;
        end
        if (cmd_i.out_next) begin
          wrd_q <= wrd_q + 3'd1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/bhe_ctrl.sv
// controller state machine sequencing bytes, compressions and digest beats
// depends on bhe_pkg and blake2b_hash_engine_unit_assert.svh
`timescale 1ns / 1ps
`include "blake2b_hash_engine_unit_assert.svh"

module bhe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  bhe_pkg::dp_sts_t sts_i,
  output bhe_pkg::dp_cmd_t cmd_o
);

  bhe_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bhe_pkg::S_IDLE:     if (in_valid_i) state_d = bhe_pkg::S_DISPATCH;
      bhe_pkg::S_DISPATCH: state_d = sts_i.need_compress ? bhe_pkg::S_INIT : bhe_pkg::S_BYTE;
      bhe_pkg::S_BYTE:     state_d = sts_i.finish ? bhe_pkg::S_PAD : bhe_pkg::S_IDLE;
      bhe_pkg::S_PAD:      state_d = bhe_pkg::S_INIT;
      bhe_pkg::S_INIT:     state_d = bhe_pkg::S_ROUND;
      bhe_pkg::S_ROUND:    if (sts_i.round_done) state_d = bhe_pkg::S_FEED;
      bhe_pkg::S_FEED:     state_d = sts_i.final_blk ? bhe_pkg::S_OUT : bhe_pkg::S_BYTE;
      bhe_pkg::S_OUT:      if (!out_stall_i && sts_i.last_word) state_d = bhe_pkg::S_START;
      bhe_pkg::S_START:    state_d = bhe_pkg::S_IDLE;
      default:             state_d = bhe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      bhe_pkg::S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      bhe_pkg::S_DISPATCH: cmd_o.blk_count = sts_i.need_compress;
      bhe_pkg::S_BYTE:     cmd_o.write_byte = 1'b1;
      bhe_pkg::S_PAD:      cmd_o.pad = 1'b1;
      bhe_pkg::S_INIT:     cmd_o.init_v = 1'b1;
      bhe_pkg::S_ROUND:    cmd_o.round_step = 1'b1;
      bhe_pkg::S_FEED:     cmd_o.feed = 1'b1;
      bhe_pkg::S_OUT: begin
        out_valid_o    = 1'b1;
        cmd_o.out_next = !out_stall_i;
      end
      bhe_pkg::S_START:    cmd_o.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bhe_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BHE_NEVER(a_no_overlap, out_valid_o && !in_stall_o, "input taken while digest pending")
  `BHE_ASSERT(a_last_restart, out_valid_o && !out_stall_i && sts_i.last_word |=> state_q == bhe_pkg::S_START, "no restart after last beat")
  `BHE_ASSERT(a_round_end, state_q == bhe_pkg::S_ROUND && sts_i.round_done |=> state_q == bhe_pkg::S_FEED, "rounds not closed by feed")

endmodule

>>> tb/sv/tb_blake2b_hash_engine_unit.sv
// self-checking testbench of the blake2b keyed hash engine: byte beats in, digest beats out
// digests are predicted by a behavioural blake2b model held here and compared beat by beat
// depends on bhe_pkg and blake2b_hash_engine_unit
`timescale 1ns / 1ps

module tb_blake2b_hash_engine_unit;

  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  bhe_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  bhe_pkg::out_item_t out_data_o;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_idx_i = bhe_pkg::CFG_DIGEST_LEN;
  logic [6:0]         cfg_data_i = '0;

  blake2b_hash_engine_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // predictor state
  logic [6:0]  digest_len_reg, key_len_reg;
  logic [63:0] chain [8];
  logic [63:0] count_lo, count_hi;
  logic [7:0]  blk [128];
  int unsigned fill, keys_seen;

  bhe_pkg::in_item_t  byte_queue [$];
  bhe_pkg::out_item_t digest_queue [$];
  int unsigned in_idle_pct = 0, out_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  function automatic int unsigned digest_bytes();
    if (digest_len_reg == 0) return 1;
    return (digest_len_reg > 64) ? 64 : digest_len_reg;
  endfunction

  function automatic int unsigned key_bytes();
    return (key_len_reg > 64) ? 64 : key_len_reg;
  endfunction

  function automatic logic [63:0] rotr64(logic [63:0] w, int unsigned c);
    return (w >> c) | (w << (64 - c));
  endfunction

  task automatic start_message();
    for (int i = 0; i < 8; i++) chain[i] = bhe_pkg::IV[i];
    chain[0] ^= 64'h0101_0000 ^ (64'(key_bytes()) << 8) ^ 64'(digest_bytes());
    count_lo = '0;
    count_hi = '0;
    for (int i = 0; i < 128; i++) blk[i] = '0;
    fill = 0;
    keys_seen = 0;
  endtask

  task automatic count_add(int unsigned n);
    logic [64:0] s;
    s = {1'b0, count_lo} + 65'(n);
    count_lo = s[63:0];
    if (s[64]) count_hi++;
  endtask

  task automatic compress_block(logic [63:0] fin);
    logic [63:0] m [16];
    logic [63:0] v [16];
    int sa [8], sb [8], sc [8], sd [8];
    int a, b, c, d, r;
    sa = '{0, 1, 2, 3, 0, 1, 2, 3};
    sb = '{4, 5, 6, 7, 5, 6, 7, 4};
    sc = '{8, 9, 10, 11, 10, 11, 8, 9};
    sd = '{12, 13, 14, 15, 15, 12, 13, 14};
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 8; j++) m[i][8*j +: 8] = blk[8*i + j];
    for (int i = 0; i < 8; i++) begin
      v[i] = chain[i];
      v[i+8] = bhe_pkg::IV[i];
    end
    v[12] ^= count_lo;
    v[13] ^= count_hi;
    v[14] ^= fin;
    for (r = 0; r < 12; r++) begin
      for (int g = 0; g < 8; g++) begin
        a = sa[g]; b = sb[g]; c = sc[g]; d = sd[g];
        v[a] = v[a] + v[b] + m[bhe_pkg::SIGMA[r % 10][2*g]];
        v[d] = rotr64(v[d] ^ v[a], 32);
        v[c] = v[c] + v[d];
        v[b] = rotr64(v[b] ^ v[c], 24);
        v[a] = v[a] + v[b] + m[bhe_pkg::SIGMA[r % 10][2*g+1]];
        v[d] = rotr64(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = rotr64(v[b] ^ v[c], 63);
      end
    end
    for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i+8];
  endtask

  task automatic predict_beat(bhe_pkg::in_item_t it);
    int unsigned kl, nw, vb;
    bhe_pkg::out_item_t o;
    kl = key_bytes();
    if (it.byte_valid) begin
      if (kl > 0 && keys_seen < kl) begin
        blk[keys_seen] = it.byte_value;
        keys_seen++;
        fill = (keys_seen == kl) ? 128 : keys_seen;
      end else begin
        if (fill >= 128) begin
          count_add(128);
          compress_block('0);
          fill = 0;
        end
        blk[fill] = it.byte_value;
        fill++;
      end
    end
    if (!it.finish) return;
    if (kl > 0 && keys_seen < kl) fill = 128;
    count_add(fill);
    for (int i = fill; i < 128; i++) blk[i] = '0;
    compress_block('1);
    nw = (digest_bytes() + 7) / 8;
    for (int k = 0; k < nw; k++) begin
      vb = digest_bytes() - 8*k;
      if (vb > 8) vb = 8;
      o.digest_word = chain[k];
      if (vb < 8) o.digest_word &= (64'd1 << (8*vb)) - 1;
      o.valid_bytes = 4'(vb);
      o.last_word = (k + 1 == nw);
      digest_queue.push_back(o);
    end
    start_message();
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** blake2b_hash_engine_unit: FAILED **");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_beat(in_data_i);
        void'(byte_queue.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= byte_queue[0];
        end else begin
          in_valid_i <= 1'b0;
          in_data_i <= bhe_pkg::in_item_t'(10'($urandom));
        end
      end
      out_stall_i <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    bhe_pkg::out_item_t exp_beat;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_queue.size() == 0) begin
        errors++;
        $display("%0t: digest beat expected none actual %h", $time, out_data_o);
      end else begin
        exp_beat = digest_queue.pop_front();
        if (out_data_o.digest_word !== exp_beat.digest_word)
          $display("%0t: digest_word expected %h actual %h", $time,
                   exp_beat.digest_word, out_data_o.digest_word);
        if (out_data_o.valid_bytes !== exp_beat.valid_bytes)
          $display("%0t: valid_bytes expected %0d actual %0d", $time,
                   exp_beat.valid_bytes, out_data_o.valid_bytes);
        if (out_data_o.last_word !== exp_beat.last_word)
          $display("%0t: last_word expected %0d actual %0d", $time,
                   exp_beat.last_word, out_data_o.last_word);
        if (out_data_o !== exp_beat) errors++;
      end
    end
  end

  task automatic push_beat(logic [7:0] b, logic bv, logic fin);
    bhe_pkg::in_item_t it;
    it.byte_value = b;
    it.byte_valid = bv;
    it.finish = fin;
    byte_queue.push_back(it);
  endtask

  task automatic drain();
    while (byte_queue.size() > 0 || in_valid_i || digest_queue.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(bhe_pkg::cfg_idx_e idx, logic [6:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bhe_pkg::CFG_DIGEST_LEN) digest_len_reg = val;
    else key_len_reg = val;
    start_message();
  endtask

  // short random message, keyed part included, sometimes with bare items
  task automatic random_message();
    int unsigned n;
    n = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) push_beat(8'($urandom), 1'b0, 1'b0);
      else push_beat(8'($urandom), 1'b1, 1'b0);
    end
    push_beat(8'($urandom), 1'($urandom_range(1)), 1'b1);
  endtask

  initial begin
    int unsigned dl_set [6], kl_set [6];
    digest_len_reg = bhe_pkg::DEF_DIGEST_LEN;
    key_len_reg = bhe_pkg::DEF_KEY_LEN;
    start_message();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty message, extremes, bare items, block edge
    push_beat(8'h00, 1'b0, 1'b1);
    push_beat(8'hff, 1'b1, 1'b1);
    push_beat(8'h55, 1'b0, 1'b0);
    push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'haa, 1'b1, 1'b1);
    drain();
    for (int i = 0; i < 128; i++) byte_queue.push_back(bhe_pkg::in_item_t'({8'(i), 2'b10}));
    push_beat(8'h00, 1'b0, 1'b1);
    drain();
    write_reg(bhe_pkg::CFG_DIGEST_LEN, 7'd0);
    write_reg(bhe_pkg::CFG_KEY_LEN, 7'd127);
    push_beat(8'h01, 1'b1, 1'b0);
    push_beat(8'h02, 1'b1, 1'b1);
    drain();
    write_reg(bhe_pkg::CFG_DIGEST_LEN, 7'd127);
    write_reg(bhe_pkg::CFG_KEY_LEN, 7'd2);
    push_beat(8'h80, 1'b1, 1'b0);
    push_beat(8'h7f, 1'b1, 1'b0);
    push_beat(8'h33, 1'b1, 1'b1);
    drain();

    dl_set = '{64, 1, 33, 7, 20, 64};
    kl_set = '{0, 64, 5, 1, 32, 0};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(bhe_pkg::CFG_DIGEST_LEN, 7'(dl_set[ph]));
      write_reg(bhe_pkg::CFG_KEY_LEN, 7'(kl_set[ph]));
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 86; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 86; end
        default: begin in_idle_pct = 36; out_stall_pct = 36; end
      endcase
      for (int m = 0; m < 2; m++) begin
        random_message();
        if (m == 0) drain();
      end
      drain();
    end

    if (errors == 0) $display("** blake2b_hash_engine_unit: PASSED **");
    else $display("** blake2b_hash_engine_unit: FAILED **");
    $finish;
  end

endmodule
